/* rtl/core/ecgrp_pkg.sv */
// Shared widths, register indexes, operand types and helpers of the R-peak detector.
`timescale 1ns / 1ps

package ecgrp_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 16;
  localparam int RATE_BITS   = 16;
  localparam int LEVEL_W     = 32;
  localparam int CNT_W       = 32;
  localparam int LEARN_W     = 16;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int DIFF_W      = LEVEL_W + 1;
  localparam int PROD_W      = DIFF_W + RATE_BITS + 1;

  localparam logic [CFG_IDX_W-1:0] CFG_INIT_SAMPLES = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA        = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_RATE  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_REFRACTORY   = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RR       = CFG_IDX_W'(4);

  localparam logic [CFG_W-1:0] INIT_SAMPLES_RST = CFG_W'(360);
  localparam logic [CFG_W-1:0] ALPHA_RST        = CFG_W'(16384);
  localparam logic [CFG_W-1:0] UPDATE_RATE_RST  = CFG_W'(8192);
  localparam logic [CFG_W-1:0] REFRACTORY_RST   = CFG_W'(72);
  localparam logic [CFG_W-1:0] MIN_RR_RST       = CFG_W'(108);

  typedef struct packed {
    logic signed [LEVEL_W-1:0] from_level;
    logic signed [LEVEL_W-1:0] to_level;
    logic [RATE_BITS-1:0]      weight;
  } blend_op_t;

  function automatic logic signed [LEVEL_W-1:0] to_level(
    input logic signed [SAMPLE_BITS-1:0] s
  );
    logic signed [LEVEL_W-1:0] ext;
    ext = LEVEL_W'(s);
    return ext <<< FRAC_BITS;
  endfunction

endpackage

/* rtl/core/ecgrp_blend.sv */
// Shared blend unit: from + floor(weight * (to - from) / 2^16), product registered.
`timescale 1ns / 1ps

module ecgrp_blend (
  input  logic                                  clk_i,
  input  ecgrp_pkg::blend_op_t                  op_i,
  output logic signed [ecgrp_pkg::LEVEL_W-1:0]  result_o
);

  logic signed [ecgrp_pkg::DIFF_W-1:0]  diff;
  logic signed [ecgrp_pkg::PROD_W-1:0]  prod_q;
  logic signed [ecgrp_pkg::PROD_W-1:0]  prod_shifted;
  logic signed [ecgrp_pkg::LEVEL_W-1:0] from_q;

  assign diff = ecgrp_pkg::DIFF_W'(op_i.to_level) - ecgrp_pkg::DIFF_W'(op_i.from_level);

  always_ff @(posedge clk_i) begin
    prod_q <= ecgrp_pkg::PROD_W'(diff) *
              ecgrp_pkg::PROD_W'($signed({1'b0, op_i.weight}));
    from_q <= op_i.from_level;
  end

  assign prod_shifted = prod_q >>> ecgrp_pkg::RATE_BITS;
  assign result_o     = from_q + $signed(prod_shifted[ecgrp_pkg::LEVEL_W-1:0]);

endmodule

/* rtl/core/ecg_r_peak_detector_core.sv */
// Top level of the ECG R-peak detector with adaptive threshold and spacing checks.
//
//   channel  direction  handshake              words
//   in       input      in_valid_i/in_stall_o   sample_i
//   out      output     out_valid_o/out_stall_i peak_found_o, threshold_level_o, learning_done_o
//   cfg      input      cfg_we_i                cfg_index_i, cfg_wdata_i
//
// A word needs no blend when no threshold work is due, that is a learning word before the
// last one or a sample that is not a candidate; only the threshold blend when only the
// threshold is recomputed; and a level blend followed by the threshold blend otherwise.
// The one shared blend multiplier serves both blends in series. Reset clears levels,
// counters and flags to defaults; the target and result word registers are not reset.
// A stalled result word holds; the next sample is taken meanwhile and waits in the last step.
`timescale 1ns / 1ps

module ecg_r_peak_detector_core (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic signed [ecgrp_pkg::SAMPLE_BITS-1:0] sample_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic                                    peak_found_o,
  output logic signed [ecgrp_pkg::LEVEL_W-1:0]    threshold_level_o,
  output logic                                    learning_done_o,
  input  logic                                    cfg_we_i,
  input  logic [ecgrp_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [ecgrp_pkg::CFG_W-1:0]             cfg_wdata_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_UPD_WAIT,
    ST_THR,
    ST_THR_WAIT,
    ST_FIN
  } state_e;

  state_e state_q, state_d;

  logic [ecgrp_pkg::CFG_W-1:0] init_samples_q, init_samples_d;
  logic [ecgrp_pkg::CFG_W-1:0] alpha_q, alpha_d;
  logic [ecgrp_pkg::CFG_W-1:0] rate_q, rate_d;
  logic [ecgrp_pkg::CFG_W-1:0] refractory_q, refractory_d;
  logic [ecgrp_pkg::CFG_W-1:0] min_rr_q, min_rr_d;

  logic signed [ecgrp_pkg::LEVEL_W-1:0]     signal_q, signal_d;
  logic signed [ecgrp_pkg::LEVEL_W-1:0]     noise_q, noise_d;
  logic signed [ecgrp_pkg::LEVEL_W-1:0]     thresh_q, thresh_d;
  logic signed [ecgrp_pkg::LEVEL_W-1:0]     target_q, target_d;
  logic signed [ecgrp_pkg::SAMPLE_BITS-1:0] prev_q, prev_d;
  logic [ecgrp_pkg::CNT_W-1:0]              cnt_q, cnt_d;
  logic [ecgrp_pkg::CNT_W-1:0]              last_peak_q, last_peak_d;
  logic [ecgrp_pkg::LEARN_W-1:0]            learn_q, learn_d;
  logic                                     learned_q, learned_d;
  logic                                     upd_signal_q, upd_signal_d;
  logic                                     found_q, found_d;

  logic                                     out_valid_q, out_valid_d;
  logic                                     out_found_q, out_found_d;
  logic signed [ecgrp_pkg::LEVEL_W-1:0]     out_thresh_q, out_thresh_d;
  logic                                     out_learned_q, out_learned_d;

  logic                                     accept;
  logic signed [ecgrp_pkg::LEVEL_W-1:0]     lv;
  logic signed [ecgrp_pkg::LEVEL_W-1:0]     pk;
  logic [ecgrp_pkg::LEARN_W-1:0]            learn_inc;
  logic [ecgrp_pkg::CNT_W-1:0]              since;
  logic                                     spacing_ok;
  ecgrp_pkg::blend_op_t                     blend_op;
  logic signed [ecgrp_pkg::LEVEL_W-1:0]     blend_res;

  ecgrp_blend u_blend (
    .clk_i    (clk_i),
    .op_i     (blend_op),
    .result_o (blend_res)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  assign lv         = ecgrp_pkg::to_level(sample_i);
  assign pk         = ecgrp_pkg::to_level(prev_q);
  assign learn_inc  = learn_q + ecgrp_pkg::LEARN_W'(1);
  assign since      = cnt_q - last_peak_q;
  assign spacing_ok = (since >= ecgrp_pkg::CNT_W'(refractory_q)) &&
                      ((since >= ecgrp_pkg::CNT_W'(min_rr_q)) ||
                       (last_peak_q == '0));

  always_comb begin
    if (state_q == ST_THR) begin
      blend_op.from_level = noise_q;
      blend_op.to_level   = signal_q;
      blend_op.weight     = alpha_q;
    end else begin
      blend_op.from_level = upd_signal_q ? signal_q : noise_q;
      blend_op.to_level   = target_q;
      blend_op.weight     = rate_q;
    end
  end

  always_comb begin
    state_d        = state_q;
    init_samples_d = init_samples_q;
    alpha_d        = alpha_q;
    rate_d         = rate_q;
    refractory_d   = refractory_q;
    min_rr_d       = min_rr_q;
    signal_d       = signal_q;
    noise_d        = noise_q;
    thresh_d       = thresh_q;
    target_d       = target_q;
    prev_d         = prev_q;
    cnt_d          = cnt_q;
    last_peak_d    = last_peak_q;
    learn_d        = learn_q;
    learned_d      = learned_q;
    upd_signal_d   = upd_signal_q;
    found_d        = found_q;
    out_valid_d    = out_valid_q && out_stall_i;
    out_found_d    = out_found_q;
    out_thresh_d   = out_thresh_q;
    out_learned_d  = out_learned_q;

    if (cfg_we_i) begin
      unique case (cfg_index_i)
        ecgrp_pkg::CFG_INIT_SAMPLES: init_samples_d = cfg_wdata_i;
        ecgrp_pkg::CFG_ALPHA:        alpha_d        = cfg_wdata_i;
        ecgrp_pkg::CFG_UPDATE_RATE:  rate_d         = cfg_wdata_i;
        ecgrp_pkg::CFG_REFRACTORY:   refractory_d   = cfg_wdata_i;
        ecgrp_pkg::CFG_MIN_RR:       min_rr_d       = cfg_wdata_i;
        default: ;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          found_d = 1'b0;
          prev_d  = sample_i;
          cnt_d   = cnt_q + ecgrp_pkg::CNT_W'(1);
          state_d = ST_FIN;
          if (!learned_q) begin
            learn_d = learn_inc;
            if (learn_inc == ecgrp_pkg::LEARN_W'(1)) begin
              signal_d = lv;
              noise_d  = lv;
            end else begin
              if (lv > signal_q) signal_d = lv;
              if (lv < noise_q)  noise_d  = lv;
            end
            if (learn_inc >= init_samples_q) begin
              learned_d = 1'b1;
              state_d   = ST_THR;
            end
          end else if (sample_i < prev_q) begin
            target_d = pk;
            if (pk > thresh_q) begin
              if (spacing_ok) begin
                found_d      = 1'b1;
                last_peak_d  = cnt_q;
                upd_signal_d = 1'b1;
                state_d      = ST_UPD;
              end else begin
                state_d = ST_THR;
              end
            end else begin
              upd_signal_d = 1'b0;
              state_d      = ST_UPD;
            end
          end
        end
      end
      ST_UPD: begin
        state_d = ST_UPD_WAIT;
      end
      ST_UPD_WAIT: begin
        if (upd_signal_q) begin
          signal_d = blend_res;
        end else begin
          noise_d = blend_res;
        end
        state_d = ST_THR;
      end
      ST_THR: begin
        state_d = ST_THR_WAIT;
      end
      ST_THR_WAIT: begin
        thresh_d = blend_res;
        state_d  = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d   = 1'b1;
          out_found_d   = found_q;
          out_thresh_d  = thresh_q;
          out_learned_d = learned_q;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      init_samples_q <= ecgrp_pkg::INIT_SAMPLES_RST;
      alpha_q        <= ecgrp_pkg::ALPHA_RST;
      rate_q         <= ecgrp_pkg::UPDATE_RATE_RST;
      refractory_q   <= ecgrp_pkg::REFRACTORY_RST;
      min_rr_q       <= ecgrp_pkg::MIN_RR_RST;
      signal_q       <= '0;
      noise_q        <= '0;
      thresh_q       <= '0;
      prev_q         <= '0;
      cnt_q          <= '0;
      last_peak_q    <= '0;
      learn_q        <= '0;
      learned_q      <= 1'b0;
      upd_signal_q   <= 1'b0;
      found_q        <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      init_samples_q <= init_samples_d;
      alpha_q        <= alpha_d;
      rate_q         <= rate_d;
      refractory_q   <= refractory_d;
      min_rr_q       <= min_rr_d;
      signal_q       <= signal_d;
      noise_q        <= noise_d;
      thresh_q       <= thresh_d;
      prev_q         <= prev_d;
      cnt_q          <= cnt_d;
      last_peak_q    <= last_peak_d;
      learn_q        <= learn_d;
      learned_q      <= learned_d;
      upd_signal_q   <= upd_signal_d;
      found_q        <= found_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    target_q      <= target_d;
    out_found_q   <= out_found_d;
    out_thresh_q  <= out_thresh_d;
    out_learned_q <= out_learned_d;
  end

  assign out_valid_o       = out_valid_q;
  assign peak_found_o      = out_found_q;
  assign threshold_level_o = out_thresh_q;
  assign learning_done_o   = out_learned_q;

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o)
    else $error("Sample word accepted without leaving idle.");

  a_peak_after_learning: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!peak_found_o || learning_done_o))
    else $error("Peak reported during learning.");

  a_thresh_zero_learning: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !learning_done_o) |-> (threshold_level_o == '0))
    else $error("Threshold nonzero before learning completed.");

  a_fin_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && !out_valid_q) |=> (out_valid_q && state_q == ST_IDLE))
    else $error("Finished result word not delivered to output register.");
`endif

endmodule

/* bench/ecg_r_peak_detector_core_tb.sv */
// Self-checking testbench for the ECG R-peak detector core, with a cycle-free behavioral predictor.
`timescale 1ns / 1ps

module ecg_r_peak_detector_core_tb;
  import ecgrp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = CFG_IDX_W'(7);
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int LONG_HOLD_AT = 600;
  localparam int MAX_PRINTED = 100;

  typedef struct {
    logic                      peak;
    logic signed [LEVEL_W-1:0] thr;
    logic                      done;
  } rpeak_result_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic signed [SAMPLE_BITS-1:0] sample_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic                          peak_found_o;
  logic signed [LEVEL_W-1:0]     threshold_level_o;
  logic                          learning_done_o;
  logic                          cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]          cfg_index_i = '0;
  logic [CFG_W-1:0]              cfg_wdata_i = '0;

  ecg_r_peak_detector_core dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .sample_i          (sample_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .peak_found_o      (peak_found_o),
    .threshold_level_o (threshold_level_o),
    .learning_done_o   (learning_done_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_wdata_i       (cfg_wdata_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predictor copy of the configuration and detector state.
  logic [CFG_W-1:0]          m_init = INIT_SAMPLES_RST;
  logic [CFG_W-1:0]          m_alpha = ALPHA_RST;
  logic [CFG_W-1:0]          m_rate = UPDATE_RATE_RST;
  logic [CFG_W-1:0]          m_refr = REFRACTORY_RST;
  logic [CFG_W-1:0]          m_min_rr = MIN_RR_RST;
  logic signed [LEVEL_W-1:0] m_sig = '0;
  logic signed [LEVEL_W-1:0] m_noise = '0;
  logic signed [LEVEL_W-1:0] m_thr = '0;
  logic signed [SAMPLE_BITS-1:0] m_prev = '0;
  logic [CNT_W-1:0]          m_count = '0;
  logic [CNT_W-1:0]          m_last_peak = '0;
  logic [LEARN_W-1:0]        m_learn_cnt = '0;
  logic                      m_learned = 1'b0;

  logic signed [SAMPLE_BITS-1:0] sample_backlog[$];
  rpeak_result_t                 pending_results[$];

  logic in_took = 1'b0;
  int   accepted_in = 0;
  int   checked_words = 0;
  int   mismatches = 0;
  int   idle_cycles = 0;
  bit   calm = 1'b0;

  int send_gap = 0;
  int send_stretch = 0;
  bit send_noisy = 1'b1;
  int stall_left = 0;
  int hold_left = 0;
  int recv_stretch = 0;
  bit recv_noisy = 1'b1;
  bit long_hold_done = 1'b0;

  int learn_words[] = '{0, 32767, -32768, 1, -1, 21845, -21846};
  int detect_words[] = '{100, 30000, 20000, 25000, 24000, -100, -200, 32767, -32768,
                         5, 5, 4, -32768, 32767, 32767};

  function automatic logic signed [LEVEL_W-1:0] blend_toward(
    input logic signed [LEVEL_W-1:0] cur,
    input logic signed [LEVEL_W-1:0] goal,
    input logic [CFG_W-1:0]          w
  );
    longint diff;
    longint prod;
    diff = longint'(goal) - longint'(cur);
    prod = diff * longint'({1'b0, w});
    return LEVEL_W'(longint'(cur) + (prod >>> RATE_BITS));
  endfunction

  task automatic track_sample(input logic signed [SAMPLE_BITS-1:0] s);
    logic signed [LEVEL_W-1:0] lv;
    logic signed [LEVEL_W-1:0] pk;
    logic [CNT_W-1:0]          since;
    rpeak_result_t             r;
    lv = {s, {FRAC_BITS{1'b0}}};
    r.peak = 1'b0;
    if (!m_learned) begin
      m_learn_cnt = m_learn_cnt + 1'b1;
      if (m_learn_cnt == 1) begin
        m_sig = lv;
        m_noise = lv;
      end else begin
        if (lv > m_sig) m_sig = lv;
        if (lv < m_noise) m_noise = lv;
      end
      if (m_learn_cnt >= m_init) begin
        m_thr = blend_toward(m_noise, m_sig, m_alpha);
        m_learned = 1'b1;
      end
    end else if (s < m_prev) begin
      pk = {m_prev, {FRAC_BITS{1'b0}}};
      if (pk > m_thr) begin
        since = m_count - m_last_peak;
        if (since >= m_refr && (since >= m_min_rr || m_last_peak == 0)) begin
          r.peak = 1'b1;
          m_last_peak = m_count;
          m_sig = blend_toward(m_sig, pk, m_rate);
        end
      end else begin
        m_noise = blend_toward(m_noise, pk, m_rate);
      end
      m_thr = blend_toward(m_noise, m_sig, m_alpha);
    end
    m_prev = s;
    m_count = m_count + 1'b1;
    r.thr = m_thr;
    r.done = m_learned;
    pending_results.push_back(r);
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTED) $display("mismatch at result word %0d: %s", checked_words, msg);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    rpeak_result_t want;
    bit moved;
    if (rst_ni) begin
      moved = cfg_we_i;
      in_took <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        track_sample(sample_i);
        accepted_in++;
        moved = 1'b1;
      end
      if (out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
        moved = 1'b1;
        if (pending_results.size() == 0) begin
          report_mismatch("result word with nothing expected");
        end else begin
          want = pending_results.pop_front();
          if (peak_found_o !== want.peak)
            report_mismatch($sformatf("peak_found %b, expected %b", peak_found_o, want.peak));
          if (threshold_level_o !== want.thr)
            report_mismatch($sformatf("threshold_level %h, expected %h",
                                      threshold_level_o, want.thr));
          if (learning_done_o !== want.done)
            report_mismatch($sformatf("learning_done %b, expected %b",
                                      learning_done_o, want.done));
        end
        checked_words++;
      end
      if (moved) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("watchdog: no word moved for %0d cycles", idle_cycles);
          $display("ecg_r_peak_detector_core_tb failed");
          $finish;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    logic nv;
    logic signed [SAMPLE_BITS-1:0] ns;
    if (rst_ni) begin
      nv = in_valid_i;
      ns = sample_i;
      if (send_stretch == 0) begin
        send_stretch = $urandom_range(20, 200);
        send_noisy = $urandom_range(0, 2) != 0;
      end else begin
        send_stretch--;
      end
      if (in_valid_i && in_took) nv = 1'b0;
      if (!nv) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (sample_backlog.size() > 0) begin
          if (!calm && send_noisy && $urandom_range(0, 5) == 0) begin
            send_gap = $urandom_range(1, 12) - 1;
          end else begin
            ns = sample_backlog.pop_front();
            nv = 1'b1;
          end
        end
      end
      in_valid_i <= nv;
      sample_i <= ns;
    end
  end

  always @(negedge clk_i) begin
    logic stall;
    if (rst_ni) begin
      if (recv_stretch == 0) begin
        recv_stretch = $urandom_range(20, 200);
        recv_noisy = $urandom_range(0, 2) != 0;
      end else begin
        recv_stretch--;
      end
      if (!long_hold_done && accepted_in >= LONG_HOLD_AT) begin
        hold_left = LONG_HOLD_CYCLES;
        long_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        stall = 1'b1;
      end else if (!calm && recv_noisy && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        stall = 1'b1;
      end else begin
        stall = 1'b0;
      end
      out_stall_i <= stall;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_INIT_SAMPLES: m_init = val;
      CFG_ALPHA:        m_alpha = val;
      CFG_UPDATE_RATE:  m_rate = val;
      CFG_REFRACTORY:   m_refr = val;
      CFG_MIN_RR:       m_min_rr = val;
      default: ;
    endcase
  endtask

  task automatic set_detection(input int init, input int alpha, input int rate,
                               input int refr, input int min_rr);
    write_reg(CFG_INIT_SAMPLES, CFG_W'(init));
    write_reg(CFG_ALPHA, CFG_W'(alpha));
    write_reg(CFG_UPDATE_RATE, CFG_W'(rate));
    write_reg(CFG_REFRACTORY, CFG_W'(refr));
    write_reg(CFG_MIN_RR, CFG_W'(min_rr));
  endtask

  task automatic wait_drained();
    while (sample_backlog.size() != 0 || in_valid_i || pending_results.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic push_clamped(input int v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    sample_backlog.push_back(SAMPLE_BITS'(v));
  endtask

  // Beats are a noisy baseline followed by a sharp rise and fall; the rest is raw noise
  // and runs of rail-to-rail or repeated words.
  task automatic queue_ecg(input int count);
    int n;
    int base;
    int amp;
    int top;
    int len;
    int rise;
    int fall;
    int v;
    n = 0;
    while (n < count) begin
      case ($urandom_range(0, 9))
        7, 8: begin
          len = $urandom_range(1, 20);
          repeat (len) begin
            push_clamped(int'($signed(SAMPLE_BITS'($urandom()))));
            n++;
          end
        end
        9: begin
          v = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
          if ($urandom_range(0, 2) == 0) v = int'($urandom_range(0, 2000)) - 1000;
          len = $urandom_range(2, 6);
          repeat (len) begin
            push_clamped(v);
            n++;
          end
        end
        default: begin
          base = int'($urandom_range(0, 4000)) - 2000;
          amp = int'($urandom_range(0, 300));
          len = $urandom_range(2, 40);
          repeat (len) begin
            push_clamped(base + int'($urandom_range(0, 2 * amp)) - amp);
            n++;
          end
          top = base + int'($urandom_range(1000, 34000));
          rise = $urandom_range(1, 4);
          fall = $urandom_range(1, 5);
          for (int k = 1; k <= rise; k++) begin
            push_clamped(base + (top - base) * k / rise);
            n++;
          end
          for (int k = 1; k <= fall; k++) begin
            push_clamped(top - (top - base + int'($urandom_range(0, 3000))) * k / fall);
            n++;
          end
        end
      endcase
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Learning with the longest setting tracks max and min, then a zero length ends it.
    write_reg(CFG_INIT_SAMPLES, CFG_W'(65535));
    foreach (learn_words[k]) push_clamped(learn_words[k]);
    wait_drained();
    set_detection(0, 32768, 65535, 0, 0);
    foreach (detect_words[k]) push_clamped(detect_words[k]);
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: set_detection(1, 0, 0, 0, 0);
        1: set_detection(65535, 65535, 65535, 65535, 65535);
        2: set_detection(360, 16384, 8192, 10, 20);
        3: set_detection($urandom_range(1, 65535), 65535, 0, 0, 65535);
        default: set_detection($urandom_range(1, 65535), $urandom_range(0, 65535),
                               $urandom_range(0, 65535), $urandom_range(0, 60),
                               $urandom_range(0, 80));
      endcase
      if (p == 3) write_reg(CFG_SPARE_IDX, CFG_W'($urandom_range(0, 65535)));
      if (p == 7) calm = 1'b1;
      queue_ecg(240);
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d expected result words never arrived",
                                pending_results.size()));
    if (mismatches == 0) begin
      $display("ecg_r_peak_detector_core_tb passed");
    end else begin
      $display("ecg_r_peak_detector_core_tb failed");
    end
    $finish;
  end

endmodule
